// ===== hw/rtl/tpw_pkg.sv =====
package tpw_pkg;

    // Ring depth per side and derived widths.
    localparam int WINDOW_MAX = 64;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int DEPTH      = 2 * WINDOW_MAX;

    localparam int PRICE_W = 31;
    localparam int CFG_W   = 7;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(64);
    localparam logic [PRICE_W-1:0] EMPTY_MIN = {PRICE_W{1'b1}};

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_W-1:0]     wr_addr;
        logic [PRICE_W-1:0]    wr_data;
        logic                  rd_en;
        logic [ADDR_W-1:0]     rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic clear;
        logic enable;
    } scan_ctrl_t;

endpackage

// ===== hw/rtl/tpw_if.sv =====
interface trade_if
    import tpw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               trade_side;
    logic [PRICE_W-1:0] trade_price;

    modport source (output valid, output trade_side, output trade_price, input ready);
    modport sink   (input valid, input trade_side, input trade_price, output ready);
endinterface

interface result_if
    import tpw_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               result_side;
    logic               accepted;
    logic               window_empty;
    logic [PRICE_W-1:0] min_price;
    logic [PRICE_W-1:0] max_price;

    modport source (
        output valid, output result_side, output accepted, output window_empty,
        output min_price, output max_price, input ready
    );
    modport sink (
        input valid, input result_side, input accepted, input window_empty,
        input min_price, input max_price, output ready
    );
endinterface

// ===== hw/rtl/tpw_window_ram.sv =====
module tpw_window_ram
    import tpw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ram_req_t           req,
    output logic [PRICE_W-1:0] rd_data
);

    // Both sides share one memory; the top address bit selects the side.
    // Entries never written read as zero through the valid bits.
    logic [PRICE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [PRICE_W-1:0] data_reg;
    logic               hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

// ===== hw/rtl/tpw_min_max_unit.sv =====
module tpw_min_max_unit
    import tpw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scan_ctrl_t         ctrl,
    input  logic [PRICE_W-1:0] value,
    output logic [PRICE_W-1:0] min_price,
    output logic [PRICE_W-1:0] max_price
);

    logic [PRICE_W-1:0] min_reg;
    logic [PRICE_W-1:0] max_reg;
    logic [PRICE_W-1:0] min_next;
    logic [PRICE_W-1:0] max_next;

    // Zero entries hold no price and are skipped.
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.clear)
        begin
            min_next = EMPTY_MIN;
            max_next = '0;
        end
        else if (ctrl.enable && (value != '0))
        begin
            if (value < min_reg)
            begin
                min_next = value;
            end
            if (value > max_reg)
            begin
                max_next = value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= EMPTY_MIN;
            max_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign min_price = min_reg;
    assign max_price = max_reg;

endmodule

// ===== hw/rtl/trade_price_window_min_max.sv =====
// Trade price window minimum and maximum.
// Trade transactions enter on the trade channel (valid/ready, side and price) and
// one result transaction leaves on the result channel for every trade: the side,
// an accepted flag, an empty flag and that side's window minimum and maximum.
// The window length register must be written through cfg_we/cfg_wdata only while
// idle, by the user; the block itself does not enforce this. A trade repeating
// the side's last accepted price goes from acceptance straight to the done state,
// with no write and no scan. Any other trade is written to the shared window
// memory and the side's window is then read back one entry per cycle through a
// single compare unit over the memory's single read port, passing through the
// write, scan, drain and done states. One trade is in flight at a time;
// trade.ready is high only while the sequencer idles.
// Reset clears all window entries through per-entry valid bits, so no clearing
// pass is needed, and sets the length to 64. The result is held in an output
// register; if the receiver stalls, a finished trade waits until that register
// is free, and the trade channel stays closed meanwhile.
module trade_price_window_min_max
    import tpw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    trade_if.sink            trade,
    result_if.source         result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [CFG_W-1:0]   cfg_len_reg;

    // Per-side bookkeeping, indexed by side.
    logic [PRICE_W-1:0] last_reg [2];
    logic [IDX_W-1:0]   slot_reg [2];
    logic [PRICE_W-1:0] min_reg  [2];
    logic [PRICE_W-1:0] max_reg  [2];

    // The trade in flight.
    logic               side_reg;
    logic [PRICE_W-1:0] price_reg;
    logic               acc_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               rd_pend_reg;

    // Output register.
    logic               out_valid_reg;
    logic               out_side_reg;
    logic               out_acc_reg;
    logic [PRICE_W-1:0] out_min_reg;
    logic [PRICE_W-1:0] out_max_reg;

    logic [LEN_W-1:0]   len_eff;
    logic [IDX_W-1:0]   slot_eff;
    logic [IDX_W-1:0]   slot_after;
    logic               scan_last;
    logic               take;
    logic               out_free;
    logic               trade_differs;

    ram_req_t           ram_req;
    scan_ctrl_t         scan_ctrl;
    logic [PRICE_W-1:0] rd_data;
    logic [PRICE_W-1:0] unit_min;
    logic [PRICE_W-1:0] unit_max;
    logic [PRICE_W-1:0] rep_min;
    logic [PRICE_W-1:0] rep_max;

    // A length of zero acts as one, and one above the depth acts as the depth.
    always_comb
    begin
        priority if (cfg_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(cfg_len_reg) > 32'(WINDOW_MAX))
        begin
            len_eff = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = LEN_W'(cfg_len_reg);
        end
    end

    // A slot left beyond a shrunken window restarts at entry zero.
    always_comb
    begin
        slot_eff = (LEN_W'(slot_reg[side_reg]) >= len_eff) ? '0 : slot_reg[side_reg];
        slot_after = ((LEN_W'(slot_eff) + LEN_W'(1)) >= len_eff) ? '0 : slot_eff + IDX_W'(1);
    end

    assign scan_last     = (LEN_W'(scan_idx_reg) == (len_eff - LEN_W'(1)));
    assign take          = trade.valid && trade.ready;
    assign out_free      = !out_valid_reg || result.ready;
    assign trade_differs = (trade.trade_price != last_reg[trade.trade_side]);
    assign trade.ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        ram_req.wr_en   = (state_reg == ST_WRITE);
        ram_req.wr_addr = {side_reg, slot_eff};
        ram_req.wr_data = price_reg;
        ram_req.rd_en   = (state_reg == ST_SCAN);
        ram_req.rd_addr = {side_reg, scan_idx_reg};
        scan_ctrl.clear  = (state_reg == ST_WRITE);
        scan_ctrl.enable = rd_pend_reg;
    end

    tpw_window_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    tpw_min_max_unit u_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .value     (rd_data),
        .min_price (unit_min),
        .max_price (unit_max)
    );

    // A rejected trade reports the stored figures of its side.
    assign rep_min = acc_reg ? unit_min : min_reg[side_reg];
    assign rep_max = acc_reg ? unit_max : max_reg[side_reg];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = trade_differs ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_len_reg   <= CFG_RESET;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            scan_idx_reg  <= '0;
            acc_reg       <= 1'b0;
            for (int s = 0; s < 2; s++)
            begin
                last_reg[s] <= '0;
                slot_reg[s] <= '0;
                min_reg[s]  <= EMPTY_MIN;
                max_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= ram_req.rd_en;

            if (cfg_we)
            begin
                cfg_len_reg <= cfg_wdata;
            end

            if (take)
            begin
                acc_reg <= trade_differs;
            end

            if (state_reg == ST_WRITE)
            begin
                last_reg[side_reg] <= price_reg;
                slot_reg[side_reg] <= slot_after;
                scan_idx_reg       <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end

            if ((state_reg == ST_DONE) && acc_reg)
            begin
                min_reg[side_reg] <= unit_min;
                max_reg[side_reg] <= unit_max;
            end

            // The result stays until the receiver takes it.
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            side_reg  <= trade.trade_side;
            price_reg <= trade.trade_price;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_side_reg <= side_reg;
            out_acc_reg  <= acc_reg;
            out_min_reg  <= rep_min;
            out_max_reg  <= rep_max;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.result_side  = out_side_reg;
    assign result.accepted     = out_acc_reg;
    assign result.window_empty = (out_max_reg == '0);
    assign result.min_price    = out_min_reg;
    assign result.max_price    = out_max_reg;

endmodule
